### hw/rtl/cseh_pkg.sv
// types and constants shared by the control surface event handler
package cseh_pkg;

  // one input item
  typedef struct packed {
    logic       cmd;
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [2:0]  event_kind;
    logic [2:0]  strip;
    logic [1:0]  button_group;
    logic [13:0] event_value;
    logic        send_midi;
    logic [7:0]  out_status;
    logic [6:0]  out_first;
    logic [6:0]  out_second;
    logic        last_of_run;
  } out_item_t;

  // decoded message operation
  typedef enum logic [2:0] {
    OP_NONE,
    OP_FADER,
    OP_TOUCH,
    OP_BUTTON,
    OP_ENCODER
  } msg_op_t;

  // decoder result handed to the sequencer
  typedef struct packed {
    msg_op_t    op;
    logic [2:0] strip;
    logic [1:0] group;
    logic       flag;
    logic       up;
  } dec_t;

  // result kinds
  localparam logic [2:0] KIND_FADER  = 3'd0;
  localparam logic [2:0] KIND_TOUCH  = 3'd1;
  localparam logic [2:0] KIND_BUTTON = 3'd2;
  localparam logic [2:0] KIND_RING   = 3'd3;
  localparam logic [2:0] KIND_ECHO   = 3'd4;

  // message type nibbles
  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_CTRL     = 4'hB;
  localparam logic [3:0] TYPE_BEND     = 4'hE;

  // note and controller numbers
  localparam logic [6:0] TOUCH_BASE   = 7'd104;
  localparam logic [6:0] RING_CC_IN   = 7'd80;
  localparam logic [6:0] RING_CC_OUT  = 7'd48;
  localparam logic [6:0] ENC_CENTER   = 7'd64;
  localparam logic [6:0] LED_ON_VALUE = 7'd127;

  // outgoing status bytes
  localparam logic [7:0] STATUS_NOTE_ON = 8'h90;
  localparam logic [7:0] STATUS_CTRL    = 8'hB0;
  localparam logic [7:0] STATUS_BEND    = 8'hE0;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_MAX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_MODE  = 2'd2;

endpackage

### hw/rtl/cseh_decode.sv
// message classifier: picks the operation, strip and button group of a midi request
module cseh_decode import cseh_pkg::*; #(
  parameter int STRIPS        = 8,
  parameter int BUTTON_GROUPS = 4
) (
  input  in_item_t item,
  output dec_t     dec
);

  logic [3:0] msg_type;
  logic [3:0] chan;
  logic [6:0] d1;
  logic [6:0] d2;
  logic       is_touch;
  logic       is_button;
  logic       is_ring;
  logic [1:0] btn_group;
  logic [2:0] btn_strip;

  assign msg_type = item.status_byte[7:4];
  assign chan     = item.status_byte[3:0];
  assign d1       = item.data_one;
  assign d2       = item.data_two;

  // note and controller ranges
  assign is_touch  = (msg_type == TYPE_NOTE_ON || msg_type == TYPE_NOTE_OFF) &&
                     d1 >= TOUCH_BASE && d1 < TOUCH_BASE + 7'(STRIPS);
  assign is_button = msg_type == TYPE_NOTE_ON && d2 != 7'd0 &&
                     d1 < 7'(BUTTON_GROUPS * STRIPS);
  assign is_ring   = msg_type == TYPE_CTRL &&
                     d1 >= RING_CC_IN && d1 < RING_CC_IN + 7'(STRIPS);

  // button note split into group and strip by constant thresholds
  always_comb begin
    btn_group = 2'd0;
    btn_strip = d1[2:0];
    for (int g = 0; g < BUTTON_GROUPS; g++) begin
      if (d1 >= 7'(g * STRIPS)) begin
        btn_group = 2'(g);
        btn_strip = 3'(d1 - 7'(g * STRIPS));
      end
    end
  end

  // priority follows the message handling order
  always_comb begin
    dec       = '0;
    dec.op    = OP_NONE;
    dec.flag  = msg_type == TYPE_NOTE_ON && d2 != 7'd0;
    dec.up    = d2 < ENC_CENTER;
    dec.group = 2'd0;
    if (item.cmd) begin
      dec.op = OP_NONE;
    end else if (msg_type == TYPE_BEND) begin
      if (chan < 4'(STRIPS)) begin
        dec.op    = OP_FADER;
        dec.strip = chan[2:0];
      end
    end else if (is_touch) begin
      dec.op    = OP_TOUCH;
      dec.strip = 3'(d1 - TOUCH_BASE);
    end else if (is_button) begin
      dec.op    = OP_BUTTON;
      dec.strip = btn_strip;
      dec.group = btn_group;
    end else if (is_ring) begin
      if (d2 != 7'd0 && d2 != ENC_CENTER) begin
        dec.op    = OP_ENCODER;
        dec.strip = 3'(d1 - RING_CC_IN);
      end
    end
  end

endmodule

### hw/rtl/control_surface_event_handler.sv
// top level of the control surface event handler: sequencer, state and result register
//
// Usage: item_valid/item_ready carries one request at a time, either a decoded
// three-byte midi message (cmd 0) or a time tick (cmd 1). result_valid/result_ready
// carries the result items; last_of_run marks the final result of a request.
// cfg_valid/cfg_ready writes hold_ticks (index 0), ring_max (1) and ring_mode (2);
// cfg_ready is always high, and writes belong to idle periods only.
// Sequencing: a message is registered at acceptance, handled in the next cycle
// and its single result, if it gives one, is presented in the cycle after. A
// tick walks the hold countdowns one strip per cycle, pausing at each echo until
// the receiver takes it, through one shared increment/decrement unit.
// item_ready is high only while the sequencer is idle.
// A stalled receiver holds the sequencer: the result register keeps its item and
// the strip scan resumes once it is taken.
// Reset clears the configuration to hold_ticks 2, ring_max 11, ring_mode 2, disarms
// all hold countdowns, turns all buttons off and zeroes the encoder counters.
module control_surface_event_handler import cseh_pkg::*; #(
  parameter int STRIPS        = 8,
  parameter int BUTTON_GROUPS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  in_item_t             item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output out_item_t            result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int IDX_W   = (STRIPS > 1) ? $clog2(STRIPS) : 1;
  localparam int NBTN    = BUTTON_GROUPS * STRIPS;
  localparam int BTN_W   = (NBTN > 1) ? $clog2(NBTN) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STRIPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MSG,
    ST_SCAN,
    ST_WAIT_MSG,
    ST_WAIT_SCAN
  } state_t;

  state_t     state;
  in_item_t   req;
  logic [IDX_W-1:0] idx;

  // configuration
  logic [7:0] hold_ticks;
  logic [3:0] ring_max;
  logic [2:0] ring_mode;

  // per-strip and per-button state
  logic [13:0] fader_level   [STRIPS];
  logic [7:0]  hold_count    [STRIPS];
  logic        hold_armed    [STRIPS];
  logic [3:0]  encoder_level [STRIPS];
  logic        button_toggle [NBTN];

  dec_t             dec;
  logic [IDX_W-1:0] dstrip;
  logic [BTN_W-1:0] bidx;
  logic             btn_on;

  // shared increment/decrement unit
  logic [7:0] unit_a;
  logic       unit_up;
  logic [7:0] unit_y;
  logic [3:0] enc_next;

  logic       fire;
  logic       later_fire;
  out_item_t  msg_out;
  out_item_t  echo_out;

  cseh_decode #(
    .STRIPS        (STRIPS),
    .BUTTON_GROUPS (BUTTON_GROUPS)
  ) u_decode (
    .item (req),
    .dec  (dec)
  );

  assign dstrip     = dec.strip[IDX_W-1:0];
  assign bidx       = req.data_one[BTN_W-1:0];
  assign btn_on     = !button_toggle[bidx];
  assign item_ready = state == ST_IDLE;
  assign cfg_ready  = 1'b1;

  // operand select and the unit itself
  assign unit_a  = (state == ST_SCAN) ? hold_count[idx] : {4'd0, encoder_level[dstrip]};
  assign unit_up = (state != ST_SCAN) && dec.up;
  assign unit_y  = unit_up ? unit_a + 8'd1 : ((unit_a == 8'd0) ? 8'd0 : unit_a - 8'd1);
  assign enc_next = (unit_y > {4'd0, ring_max}) ? ring_max : unit_y[3:0];

  // countdown expiry at the scanned strip and at any later strip
  assign fire = hold_armed[idx] && hold_count[idx] <= 8'd1;
  always_comb begin
    later_fire = 1'b0;
    for (int j = 0; j < STRIPS; j++) begin
      if (IDX_W'(j) > idx && hold_armed[j] && hold_count[j] <= 8'd1) begin
        later_fire = 1'b1;
      end
    end
  end

  // message result
  always_comb begin
    msg_out              = '0;
    msg_out.strip        = dec.strip;
    msg_out.last_of_run  = 1'b1;
    case (dec.op)
      OP_FADER: begin
        msg_out.event_kind  = KIND_FADER;
        msg_out.event_value = {req.data_two, req.data_one};
      end
      OP_TOUCH: begin
        msg_out.event_kind  = KIND_TOUCH;
        msg_out.event_value = {13'd0, dec.flag};
      end
      OP_BUTTON: begin
        msg_out.event_kind   = KIND_BUTTON;
        msg_out.button_group = dec.group;
        msg_out.event_value  = {13'd0, btn_on};
        msg_out.send_midi    = 1'b1;
        msg_out.out_status   = STATUS_NOTE_ON;
        msg_out.out_first    = req.data_one;
        msg_out.out_second   = btn_on ? LED_ON_VALUE : 7'd0;
      end
      OP_ENCODER: begin
        msg_out.event_kind  = KIND_RING;
        msg_out.event_value = {10'd0, enc_next};
        msg_out.send_midi   = 1'b1;
        msg_out.out_status  = STATUS_CTRL;
        msg_out.out_first   = RING_CC_OUT + 7'(dec.strip);
        msg_out.out_second  = {ring_mode, enc_next};
      end
      default: begin
        msg_out.last_of_run = 1'b1;
      end
    endcase
  end

  // hold echo result
  always_comb begin
    echo_out             = '0;
    echo_out.event_kind  = KIND_ECHO;
    echo_out.strip       = 3'(idx);
    echo_out.event_value = fader_level[idx];
    echo_out.send_midi   = 1'b1;
    echo_out.out_status  = STATUS_BEND | {5'd0, 3'(idx)};
    echo_out.out_first   = fader_level[idx][6:0];
    echo_out.out_second  = fader_level[idx][13:7];
    echo_out.last_of_run = !later_fire;
  end

  // sequencer, state arrays and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      idx          <= '0;
      result_valid <= 1'b0;
      hold_ticks   <= 8'd2;
      ring_max     <= 4'd11;
      ring_mode    <= 3'd2;
      for (int s = 0; s < STRIPS; s++) begin
        fader_level[s]   <= 14'd0;
        hold_count[s]    <= 8'd0;
        hold_armed[s]    <= 1'b0;
        encoder_level[s] <= 4'd0;
      end
      for (int b = 0; b < NBTN; b++) begin
        button_toggle[b] <= 1'b0;
      end
    end else begin
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HOLD_TICKS: hold_ticks <= cfg_data;
          CFG_RING_MAX:   ring_max   <= cfg_data[3:0];
          CFG_RING_MODE:  ring_mode  <= cfg_data[2:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          idx <= '0;
          if (item_valid) begin
            req   <= item;
            state <= item.cmd ? ST_SCAN : ST_MSG;
          end
        end

        ST_MSG: begin
          case (dec.op)
            OP_FADER: begin
              fader_level[dstrip] <= {req.data_two, req.data_one};
              hold_count[dstrip]  <= hold_ticks;
              hold_armed[dstrip]  <= 1'b1;
            end
            OP_BUTTON: begin
              button_toggle[bidx] <= btn_on;
            end
            OP_ENCODER: begin
              encoder_level[dstrip] <= enc_next;
            end
            default: ;
          endcase
          result <= msg_out;
          if (dec.op == OP_NONE) begin
            state <= ST_IDLE;
          end else begin
            result_valid <= 1'b1;
            state        <= ST_WAIT_MSG;
          end
        end

        ST_SCAN: begin
          if (hold_armed[idx]) begin
            if (fire) begin
              hold_count[idx] <= 8'd0;
              hold_armed[idx] <= 1'b0;
            end else begin
              hold_count[idx] <= unit_y;
            end
          end
          result <= echo_out;
          if (fire) begin
            result_valid <= 1'b1;
            state        <= ST_WAIT_SCAN;
          end else if (idx == LAST_IDX) begin
            state <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        ST_WAIT_MSG: begin
          if (result_ready) begin
            result_valid <= 1'b0;
            state        <= ST_IDLE;
          end
        end

        ST_WAIT_SCAN: begin
          if (result_ready) begin
            result_valid <= 1'b0;
            if (idx == LAST_IDX) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_SCAN;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // a request keeps the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("request accepted while a previous one is in progress");

  // no request is taken while a result waits
  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !item_ready)
    else $error("input ready while a result is pending");

  // an echo only comes out of the countdown scan, for a strip that exists
  a_echo_from_scan: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.event_kind == KIND_ECHO |->
      state == ST_WAIT_SCAN && {1'b0, result.strip} < 4'(STRIPS))
    else $error("hold echo outside the countdown scan");
`endif

endmodule

### tb/sv/tb.sv
// testbench for the control surface event handler: directed, register, random and receiver stall traffic
module tb;
  import cseh_pkg::*;

  localparam int NUM_STRIPS = 8;
  localparam int NUM_BUTTONS = 32;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // clock, reset and ports
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  in_item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_item_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // surface state as predicted
  logic [13:0] fader_lvl [NUM_STRIPS];
  logic [7:0] hold_left [NUM_STRIPS];
  logic hold_on [NUM_STRIPS];
  logic touched [NUM_STRIPS];
  logic btn_on [NUM_BUTTONS];
  logic [3:0] enc_lvl [NUM_STRIPS];
  logic [7:0] hold_ticks_cfg = 8'd2;
  logic [3:0] ring_max_cfg = 4'd11;
  logic [2:0] ring_mode_cfg = 3'd2;

  // expected surface events, oldest first
  out_item_t pending_results [$];
  out_item_t oldest_result;

  // traffic shaping and bookkeeping
  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 78;
  int stall_cycles_left = 0;
  int mismatch_count = 0;
  int requests_sent = 0;
  int reg_writes = 0;
  int results_checked = 0;
  int kind_count [5] = '{default: 0};

  control_surface_event_handler dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  // build one expected event
  function automatic out_item_t make_event(logic [2:0] kind, int unsigned s, int unsigned grp,
                                           int unsigned val, bit send, int unsigned st,
                                           int unsigned d_first, int unsigned d_second);
    out_item_t r;
    r.event_kind = kind;
    r.strip = 3'(s);
    r.button_group = 2'(grp);
    r.event_value = 14'(val);
    r.send_midi = send;
    r.out_status = 8'(st);
    r.out_first = 7'(d_first);
    r.out_second = 7'(d_second);
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // work out the events caused by one request and update the surface state
  function automatic void surface_predict(in_item_t req);
    out_item_t run [$];
    logic [3:0] msg_type;
    logic [3:0] chan;
    int unsigned d1;
    int unsigned d2;
    int unsigned s;
    int nxt;
    logic now_on;
    msg_type = req.status_byte[7:4];
    chan = req.status_byte[3:0];
    d1 = req.data_one;
    d2 = req.data_two;
    if (req.cmd) begin
      // tick: count down each armed hold in strip order
      for (s = 0; s < NUM_STRIPS; s++) begin
        if (hold_on[s]) begin
          if (hold_left[s] <= 8'd1) begin
            hold_left[s] = 8'd0;
            hold_on[s] = 1'b0;
            run.push_back(make_event(KIND_ECHO, s, 0, fader_lvl[s], 1'b1, STATUS_BEND | s,
                                     fader_lvl[s][6:0], fader_lvl[s][13:7]));
          end else begin
            hold_left[s] = hold_left[s] - 8'd1;
          end
        end
      end
    end else if (msg_type == TYPE_BEND) begin
      // fader move on a strip channel
      if (chan < NUM_STRIPS) begin
        fader_lvl[chan] = {req.data_two, req.data_one};
        hold_left[chan] = hold_ticks_cfg;
        hold_on[chan] = 1'b1;
        run.push_back(make_event(KIND_FADER, chan, 0, fader_lvl[chan], 1'b0, 0, 0, 0));
      end
    end else if ((msg_type == TYPE_NOTE_ON || msg_type == TYPE_NOTE_OFF) &&
                 d1 >= TOUCH_BASE && d1 < TOUCH_BASE + NUM_STRIPS) begin
      // touch sense
      s = d1 - TOUCH_BASE;
      touched[s] = (msg_type == TYPE_NOTE_ON) && d2 != 0;
      run.push_back(make_event(KIND_TOUCH, s, 0, touched[s], 1'b0, 0, 0, 0));
    end else if (msg_type == TYPE_NOTE_ON && d2 != 0 && d1 < NUM_BUTTONS) begin
      // button press toggles and lights the led
      now_on = !btn_on[d1];
      btn_on[d1] = now_on;
      run.push_back(make_event(KIND_BUTTON, d1 % NUM_STRIPS, d1 / NUM_STRIPS, now_on, 1'b1,
                               STATUS_NOTE_ON, d1, now_on ? LED_ON_VALUE : 0));
    end else if (msg_type == TYPE_CTRL && d1 >= RING_CC_IN && d1 < RING_CC_IN + NUM_STRIPS) begin
      // encoder step with saturation
      s = d1 - RING_CC_IN;
      if (d2 != 0 && d2 != ENC_CENTER) begin
        if (d2 < ENC_CENTER) nxt = enc_lvl[s] + 1;
        else nxt = (enc_lvl[s] == 0) ? 0 : enc_lvl[s] - 1;
        if (nxt > ring_max_cfg) nxt = ring_max_cfg;
        enc_lvl[s] = 4'(nxt);
        run.push_back(make_event(KIND_RING, s, 0, nxt, 1'b1, STATUS_CTRL, RING_CC_OUT + s,
                                 {ring_mode_cfg, enc_lvl[s]}));
      end
    end
    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[i]) pending_results.push_back(run[i]);
  endfunction

  function automatic in_item_t midi_msg(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
    in_item_t r;
    r.cmd = 1'b0;
    r.status_byte = st;
    r.data_one = d1;
    r.data_two = d2;
    return r;
  endfunction

  // tick with junk in the ignored fields
  function automatic in_item_t tick_req();
    in_item_t r;
    r = midi_msg(8'($urandom), 7'($urandom), 7'($urandom));
    r.cmd = 1'b1;
    return r;
  endfunction

  // mostly well-formed messages with random content, some ticks and noise
  function automatic in_item_t random_request();
    in_item_t r;
    int unsigned pick;
    r = midi_msg(8'($urandom), 7'($urandom), 7'($urandom));
    pick = $urandom_range(99);
    if (pick < 22) begin
      r.status_byte = {TYPE_BEND, 1'b0, 3'($urandom)};
    end else if (pick < 25) begin
      r.status_byte[7:4] = TYPE_BEND;
    end else if (pick < 45) begin
      r.cmd = 1'b1;
    end else if (pick < 58) begin
      r.status_byte[7:4] = $urandom_range(1) ? TYPE_NOTE_ON : TYPE_NOTE_OFF;
      r.data_one = TOUCH_BASE + 7'($urandom_range(NUM_STRIPS - 1));
      if ($urandom_range(2) == 0) r.data_two = '0;
    end else if (pick < 73) begin
      r.status_byte[7:4] = ($urandom_range(9) == 0) ? TYPE_NOTE_OFF : TYPE_NOTE_ON;
      r.data_one = 7'($urandom_range(NUM_BUTTONS - 1));
      r.data_two = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
    end else if (pick < 90) begin
      r.status_byte[7:4] = TYPE_CTRL;
      r.data_one = RING_CC_IN + 7'($urandom_range(NUM_STRIPS - 1));
      case ($urandom_range(9))
        0: r.data_two = '0;
        1: r.data_two = ENC_CENTER;
        default: ;
      endcase
    end
    return r;
  endfunction

  // offer one request and wait for it to be taken
  task automatic send_request(in_item_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item <= req;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    surface_predict(req);
    requests_sent++;
  endtask

  // stop offering and wait until every expected event is back
  task automatic wait_drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_HOLD_TICKS: hold_ticks_cfg = data;
      CFG_RING_MAX: ring_max_cfg = data[3:0];
      CFG_RING_MODE: ring_mode_cfg = data[2:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random ready, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (stall_cycles_left > 0) begin
      result_ready <= 1'b0;
      stall_cycles_left = stall_cycles_left - 1;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // compare each taken event with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected event, expected none, actual %p", $time, result);
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("event_kind", oldest_result.event_kind, result.event_kind);
        check_field("strip", oldest_result.strip, result.strip);
        check_field("button_group", oldest_result.button_group, result.button_group);
        check_field("event_value", oldest_result.event_value, result.event_value);
        check_field("send_midi", oldest_result.send_midi, result.send_midi);
        check_field("out_status", oldest_result.out_status, result.out_status);
        check_field("out_first", oldest_result.out_first, result.out_first);
        check_field("out_second", oldest_result.out_second, result.out_second);
        check_field("last_of_run", oldest_result.last_of_run, result.last_of_run);
        results_checked++;
        if (result.event_kind <= KIND_ECHO) kind_count[result.event_kind]++;
      end
    end
  end

  // every message kind and its corner cases at reset settings
  task automatic test_directed();
    send_idle_pct = 22;
    recv_idle_pct = 78;
    send_request(midi_msg({TYPE_BEND, 4'd0}, 7'd0, 7'd0));
    send_request(midi_msg({TYPE_BEND, 4'd7}, 7'd127, 7'd127));
    send_request(midi_msg({TYPE_BEND, 4'd8}, 7'd5, 7'd5));
    send_request(midi_msg({TYPE_BEND, 4'd15}, 7'd1, 7'd1));
    send_request(tick_req());
    send_request(tick_req());
    send_request(tick_req());
    // touch, with the channel nibble ignored
    send_request(midi_msg({TYPE_NOTE_ON, 4'd12}, TOUCH_BASE, 7'd100));
    send_request(midi_msg({TYPE_NOTE_ON, 4'd1}, TOUCH_BASE + 7'd7, 7'd0));
    send_request(midi_msg({TYPE_NOTE_OFF, 4'd0}, TOUCH_BASE, 7'd127));
    // buttons: press, press again, release and zero velocity
    send_request(midi_msg({TYPE_NOTE_ON, 4'd0}, 7'd0, 7'd1));
    send_request(midi_msg({TYPE_NOTE_ON, 4'd5}, 7'd31, 7'd127));
    send_request(midi_msg({TYPE_NOTE_ON, 4'd0}, 7'd0, 7'd64));
    send_request(midi_msg({TYPE_NOTE_OFF, 4'd0}, 7'd5, 7'd100));
    send_request(midi_msg({TYPE_NOTE_ON, 4'd0}, 7'd5, 7'd0));
    // encoder push notes do nothing
    send_request(midi_msg({TYPE_NOTE_ON, 4'd0}, 7'd32, 7'd100));
    // encoder steps, floor at zero, dead values and neighbors of the range
    send_request(midi_msg({TYPE_CTRL, 4'd0}, RING_CC_IN, 7'd1));
    send_request(midi_msg({TYPE_CTRL, 4'd15}, RING_CC_IN + 7'd7, 7'd127));
    send_request(midi_msg({TYPE_CTRL, 4'd0}, RING_CC_IN, 7'd63));
    send_request(midi_msg({TYPE_CTRL, 4'd0}, RING_CC_IN, 7'd65));
    send_request(midi_msg({TYPE_CTRL, 4'd0}, RING_CC_IN, 7'd0));
    send_request(midi_msg({TYPE_CTRL, 4'd0}, RING_CC_IN, ENC_CENTER));
    send_request(midi_msg({TYPE_CTRL, 4'd0}, RING_CC_IN - 7'd1, 7'd1));
    send_request(midi_msg({TYPE_CTRL, 4'd0}, RING_CC_IN + 7'd8, 7'd1));
    // other message types and notes out of range
    send_request(midi_msg(8'hA3, 7'd10, 7'd10));
    send_request(midi_msg(8'h45, 7'd127, 7'd127));
    send_request(midi_msg({TYPE_NOTE_ON, 4'd0}, TOUCH_BASE + 7'd8, 7'd1));
    wait_drain();
  endtask

  // register extremes, lowered saturation limit and zero hold
  task automatic test_register_extremes();
    write_reg(CFG_HOLD_TICKS, 8'd1);
    write_reg(CFG_RING_MAX, 8'd15);
    write_reg(CFG_RING_MODE, 8'd7);
    send_request(midi_msg({TYPE_BEND, 4'd3}, 7'($urandom), 7'($urandom)));
    send_request(tick_req());
    repeat (16) begin
      send_request(midi_msg({TYPE_CTRL, 4'($urandom)}, RING_CC_IN + 7'd2,
                            7'($urandom_range(1, 63))));
    end
    wait_drain();
    // counter above the new limit falls to it
    write_reg(CFG_RING_MAX, 8'd1);
    write_reg(CFG_RING_MODE, 8'd0);
    send_request(midi_msg({TYPE_CTRL, 4'd0}, RING_CC_IN + 7'd2, 7'd100));
    send_request(midi_msg({TYPE_CTRL, 4'd0}, RING_CC_IN + 7'd2, 7'd1));
    wait_drain();
    // zero hold fires on the next tick
    write_reg(CFG_HOLD_TICKS, 8'd0);
    send_request(midi_msg({TYPE_BEND, 4'd5}, 7'($urandom), 7'($urandom)));
    send_request(tick_req());
    wait_drain();
    write_reg(CFG_HOLD_TICKS, 8'd255);
    send_request(midi_msg({TYPE_BEND, 4'd1}, 7'($urandom), 7'($urandom)));
    send_request(tick_req());
    send_request(tick_req());
    wait_drain();
    write_reg(CFG_UNUSED, 8'($urandom));
  endtask

  // random traffic under one idle mix and one random setting
  task automatic test_random_traffic(int count, int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_reg(CFG_HOLD_TICKS, 8'($urandom_range(1, 6)));
    write_reg(CFG_RING_MAX, 8'($urandom_range(1, 15)));
    write_reg(CFG_RING_MODE, 8'($urandom_range(0, 7)));
    repeat (count) send_request(random_request());
    wait_drain();
  endtask

  // long receiver hold-off while requests keep coming, then a full tick burst
  task automatic test_receiver_stall();
    int s;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_HOLD_TICKS, 8'd1);
    @(posedge clk);
    stall_cycles_left = 150;
    for (s = 0; s < NUM_STRIPS; s++) begin
      send_request(midi_msg({TYPE_BEND, 4'(s)}, 7'($urandom), 7'($urandom)));
    end
    send_request(tick_req());
    send_request(tick_req());
    wait_drain();
  endtask

  initial begin
    foreach (fader_lvl[i]) begin
      fader_lvl[i] = '0;
      hold_left[i] = '0;
      hold_on[i] = 1'b0;
      touched[i] = 1'b0;
      enc_lvl[i] = '0;
    end
    foreach (btn_on[i]) btn_on[i] = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_extremes();
    test_random_traffic(100, 22, 78);
    test_random_traffic(100, 78, 22);
    test_random_traffic(110, 0, 0);
    test_receiver_stall();
    wait_drain();
    $display("run covered %0d requests and %0d register writes over three idle mixes",
             requests_sent, reg_writes);
    $display("%0d events checked: fader %0d touch %0d button %0d ring %0d echo %0d",
             results_checked, kind_count[0], kind_count[1], kind_count[2], kind_count[3],
             kind_count[4]);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/cseh_pkg.sv
hw/rtl/cseh_decode.sv
hw/rtl/control_surface_event_handler.sv
tb/sv/tb.sv
